[design/dmcs_pkg.sv]
// ----------------------------------------------------------------------------
// dmcs_pkg
// Shared types and constants of the direct-mapped cache with statistics.
// ----------------------------------------------------------------------------
package dmcs_pkg;

    localparam int LINE_COUNT = 64;
    localparam int LINE_BYTES = 16;
    localparam int ADDR_BITS  = 16;

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int IDX_W  = $clog2(LINE_COUNT);
    localparam int TAG_W  = ADDR_BITS - OFF_W - IDX_W;
    localparam int ROW_W  = LINE_BYTES * 8;
    localparam int WB_W   = 7;
    localparam int CNT_W  = 32;
    localparam int NCNT   = 8;
    localparam int DATA_W = 64;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 112;

    typedef enum logic [2:0] {
        REQ_READ     = 3'd0,
        REQ_WRITE    = 3'd1,
        REQ_INV_LINE = 3'd2,
        REQ_FLS_LINE = 3'd3,
        REQ_INV_ALL  = 3'd4,
        REQ_FLS_ALL  = 3'd5,
        REQ_COUNTER  = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        MODE_WBACK = 2'd0,
        MODE_WTHRU = 2'd1,
        MODE_WALLOC = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_LOOK  = 2'd1,
        S_SWEEP = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    // statistics counter indexes
    localparam logic [2:0] CNT_HIT      = 3'd0;
    localparam logic [2:0] CNT_MISS     = 3'd1;
    localparam logic [2:0] CNT_RD_HIT   = 3'd2;
    localparam logic [2:0] CNT_RD_MISS  = 3'd3;
    localparam logic [2:0] CNT_WR_HIT   = 3'd4;
    localparam logic [2:0] CNT_WR_MISS  = 3'd5;
    localparam logic [2:0] CNT_EVICT    = 3'd6;
    localparam logic [2:0] CNT_WBACK    = 3'd7;

    typedef struct packed {
        logic              we_tag;
        logic              we_row;
        logic [IDX_W-1:0]  idx;
        logic [TAG_W-1:0]  tag;
        logic [ROW_W-1:0]  row;
    } t_store_wr;

    typedef struct packed {
        logic [NCNT-1:0] inc;
        logic [2:0]      sel;
    } t_stat_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]  counter_value;
        logic [WB_W-1:0]   lines_written_back;
        logic              memory_write;
        logic [3:0]        bytes_done;
        logic [DATA_W-1:0] read_data;
        logic              ok;
    } t_result;

endpackage

[design/direct_mapped_cache_with_stats_top.sv]
// Timing: a line request or counter read does its lookup in S_LOOK on the
// registered tag/data read and shows its result in S_DONE; invalidate all and
// flush all first sweep every line in S_SWEEP. One request at a time: a new
// request is taken only in S_IDLE, after the last result has been taken.
// Reset: valid and dirty bits, counters and write mode clear at once; tags and
// line data need no clearing pass.
// ----------------------------------------------------------------------------
// direct_mapped_cache_with_stats_top
// Direct-mapped cache controller with per-line valid/dirty bits and statistics.
// ----------------------------------------------------------------------------
module direct_mapped_cache_with_stats_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_wdata,   // write_mode
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // address[15:0], byte_count[19:16], write_data[83:20], zero pad
    input  logic [dmcs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [2:0]                       i_s_tuser,     // req_type
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // ok[0], read_data[64:1], bytes_done[68:65], memory_write[69],
    // lines_written_back[76:70], counter_value[108:77], zero pad
    output logic [dmcs_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int OFF_W = dmcs_pkg::OFF_W;
    localparam int IDX_W = dmcs_pkg::IDX_W;
    localparam int TAG_W = dmcs_pkg::TAG_W;
    localparam int ROW_W = dmcs_pkg::ROW_W;
    localparam int NL    = dmcs_pkg::LINE_COUNT;

    dmcs_pkg::t_state  r_state, n_state;
    logic [1:0]        r_mode;
    logic [2:0]        r_req;
    logic [15:0]       r_addr;
    logic [3:0]        r_cnt;
    logic [63:0]       r_wdata;
    logic [NL-1:0]     r_valid, n_valid;
    logic [NL-1:0]     r_dirty, n_dirty;
    logic [IDX_W-1:0]  r_sweep;
    dmcs_pkg::t_result r_res, n_res;

    logic                 accept;
    logic [TAG_W-1:0]     rd_tag;
    logic [ROW_W-1:0]     rd_row;
    dmcs_pkg::t_store_wr  st_wr;
    dmcs_pkg::t_stat_ctl  stat_ctl;
    logic [31:0]          stat_value;

    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic             hit;
    logic [3:0]       cnt8;
    logic [OFF_W:0]   room;
    logic [3:0]       nbytes;
    logic [63:0]      bmask;
    logic [ROW_W-1:0] wmask, wshift, wbase;
    logic             sw_dirty;

    assign accept = i_s_tvalid && o_s_tready;

    dmcs_store u_store (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_idx (i_s_tdata[OFF_W +: IDX_W]),
        .i_wr     (st_wr),
        .o_rd_tag (rd_tag),
        .o_rd_row (rd_row)
    );

    dmcs_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stat_ctl),
        .o_value (stat_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmcs_pkg::S_IDLE;
            r_mode  <= dmcs_pkg::MODE_WBACK;
            r_valid <= '0;
            r_dirty <= '0;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_state == dmcs_pkg::S_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end else begin
                r_sweep <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_s_tuser;
            r_addr  <= i_s_tdata[15:0];
            r_cnt   <= i_s_tdata[19:16];
            r_wdata <= i_s_tdata[83:20];
        end
        r_res <= n_res;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dmcs_pkg::S_IDLE: begin
                if (accept) n_state = dmcs_pkg::S_LOOK;
            end
            dmcs_pkg::S_LOOK: begin
                if (r_req == dmcs_pkg::REQ_INV_ALL || r_req == dmcs_pkg::REQ_FLS_ALL)
                    n_state = dmcs_pkg::S_SWEEP;
                else
                    n_state = dmcs_pkg::S_DONE;
            end
            dmcs_pkg::S_SWEEP: begin
                if (r_sweep == IDX_W'(NL - 1)) n_state = dmcs_pkg::S_DONE;
            end
            dmcs_pkg::S_DONE: begin
                if (i_m_tready) n_state = dmcs_pkg::S_IDLE;
            end
            default: n_state = dmcs_pkg::S_IDLE;
        endcase
    end

    // address split, clipping and byte lanes
    always_comb begin
        off   = r_addr[OFF_W-1:0];
        idx   = r_addr[OFF_W +: IDX_W];
        tag   = r_addr[15 -: TAG_W];
        hit   = r_valid[idx] && (rd_tag == tag);
        cnt8  = (r_cnt > 4'd8) ? 4'd8 : r_cnt;
        room  = (OFF_W+1)'(dmcs_pkg::LINE_BYTES) - {1'b0, off};
        nbytes = ({1'b0, cnt8} < room) ? cnt8 : room[3:0];
        for (int j = 0; j < 8; j++) begin
            bmask[j*8 +: 8] = (4'(j) < nbytes) ? 8'hFF : 8'h00;
        end
        wmask  = {{(ROW_W-64){1'b0}}, bmask} << {off, 3'b000};
        wshift = {{(ROW_W-64){1'b0}}, r_wdata} << {off, 3'b000};
        sw_dirty = r_valid[r_sweep] && r_dirty[r_sweep];
    end

    // outputs and datapath
    always_comb begin
        n_valid      = r_valid;
        n_dirty      = r_dirty;
        n_res        = r_res;
        stat_ctl.inc = '0;
        stat_ctl.sel = r_addr[2:0];
        st_wr.we_tag = 1'b0;
        st_wr.we_row = 1'b0;
        st_wr.idx    = idx;
        st_wr.tag    = tag;
        wbase        = rd_row;
        st_wr.row    = (wbase & ~wmask) | (wshift & wmask);
        o_s_tready   = (r_state == dmcs_pkg::S_IDLE);
        o_m_tvalid   = (r_state == dmcs_pkg::S_DONE);

        case (r_state)
            dmcs_pkg::S_LOOK: begin
                n_res = '0;
                case (r_req)
                    dmcs_pkg::REQ_READ: begin
                        if (r_cnt != 4'd0) begin
                            if (hit) begin
                                stat_ctl.inc[dmcs_pkg::CNT_HIT]    = 1'b1;
                                stat_ctl.inc[dmcs_pkg::CNT_RD_HIT] = 1'b1;
                                n_res.ok         = 1'b1;
                                n_res.bytes_done = nbytes;
                                n_res.read_data  = 64'(rd_row >> {off, 3'b000}) & bmask;
                            end else begin
                                stat_ctl.inc[dmcs_pkg::CNT_MISS]    = 1'b1;
                                stat_ctl.inc[dmcs_pkg::CNT_RD_MISS] = 1'b1;
                            end
                        end
                    end
                    dmcs_pkg::REQ_WRITE: begin
                        if (r_cnt != 4'd0) begin
                            if (hit) begin
                                stat_ctl.inc[dmcs_pkg::CNT_HIT]    = 1'b1;
                                stat_ctl.inc[dmcs_pkg::CNT_WR_HIT] = 1'b1;
                                st_wr.we_row     = 1'b1;
                                n_res.ok         = 1'b1;
                                n_res.bytes_done = nbytes;
                                if (r_mode == dmcs_pkg::MODE_WBACK) begin
                                    n_dirty[idx] = 1'b1;
                                end else if (r_mode == dmcs_pkg::MODE_WTHRU) begin
                                    n_res.memory_write = 1'b1;
                                    if (r_dirty[idx]) begin
                                        n_dirty[idx] = 1'b0;
                                        stat_ctl.inc[dmcs_pkg::CNT_WBACK] = 1'b1;
                                        n_res.lines_written_back = 7'd1;
                                    end
                                end
                            end else begin
                                stat_ctl.inc[dmcs_pkg::CNT_MISS]    = 1'b1;
                                stat_ctl.inc[dmcs_pkg::CNT_WR_MISS] = 1'b1;
                                if (r_mode == dmcs_pkg::MODE_WALLOC) begin
                                    // evict, then install a zeroed clean line
                                    if (r_valid[idx]) begin
                                        stat_ctl.inc[dmcs_pkg::CNT_EVICT] = 1'b1;
                                        if (r_dirty[idx]) begin
                                            stat_ctl.inc[dmcs_pkg::CNT_WBACK] = 1'b1;
                                            n_res.lines_written_back = 7'd1;
                                        end
                                    end
                                    wbase            = '0;
                                    st_wr.row        = wshift & wmask;
                                    st_wr.we_tag     = 1'b1;
                                    st_wr.we_row     = 1'b1;
                                    n_valid[idx]     = 1'b1;
                                    n_dirty[idx]     = 1'b0;
                                    n_res.ok         = 1'b1;
                                    n_res.bytes_done = nbytes;
                                end
                            end
                        end
                    end
                    dmcs_pkg::REQ_INV_LINE, dmcs_pkg::REQ_FLS_LINE: begin
                        if (hit) begin
                            n_res.ok = 1'b1;
                            if (r_dirty[idx]) begin
                                stat_ctl.inc[dmcs_pkg::CNT_WBACK] = 1'b1;
                                n_res.lines_written_back = 7'd1;
                            end
                            n_dirty[idx] = 1'b0;
                            if (r_req == dmcs_pkg::REQ_INV_LINE) n_valid[idx] = 1'b0;
                        end
                    end
                    dmcs_pkg::REQ_INV_ALL, dmcs_pkg::REQ_FLS_ALL: begin
                        n_res.ok = 1'b1;
                    end
                    dmcs_pkg::REQ_COUNTER: begin
                        n_res.ok            = 1'b1;
                        n_res.counter_value = stat_value;
                    end
                    default: n_res = '0;
                endcase
            end
            dmcs_pkg::S_SWEEP: begin
                // one line per cycle
                if (sw_dirty) begin
                    stat_ctl.inc[dmcs_pkg::CNT_WBACK] = 1'b1;
                    n_res.lines_written_back = r_res.lines_written_back + 1'b1;
                end
                if (r_valid[r_sweep]) n_dirty[r_sweep] = 1'b0;
                if (r_req == dmcs_pkg::REQ_INV_ALL) begin
                    n_valid[r_sweep] = 1'b0;
                    n_dirty[r_sweep] = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tdata = {3'b000, r_res};

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is pending");

    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == dmcs_pkg::S_LOOK))
        else $error("accepted request did not start lookup");

    a_memw_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res.memory_write) |-> r_res.ok)
        else $error("memory write without a hit");

    a_wb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_res.lines_written_back <= 7'(NL)))
        else $error("too many lines written back");

    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmcs_pkg::S_DONE && $past(r_state) == dmcs_pkg::S_SWEEP
            && r_req == dmcs_pkg::REQ_INV_ALL) |-> (r_valid == '0))
        else $error("invalidate all left a valid line");

endmodule

[design/dmcs_store.sv]
// ----------------------------------------------------------------------------
// dmcs_store
// Tag and line data memories, one row per line, registered read.
// ----------------------------------------------------------------------------
module dmcs_store (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [dmcs_pkg::IDX_W-1:0] i_rd_idx,
    input  dmcs_pkg::t_store_wr        i_wr,
    output logic [dmcs_pkg::TAG_W-1:0] o_rd_tag,
    output logic [dmcs_pkg::ROW_W-1:0] o_rd_row
);

    logic [dmcs_pkg::TAG_W-1:0] r_tag_mem [dmcs_pkg::LINE_COUNT];
    logic [dmcs_pkg::ROW_W-1:0] r_row_mem [dmcs_pkg::LINE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr.we_tag) begin
            r_tag_mem[i_wr.idx] <= i_wr.tag;
        end
        if (i_wr.we_row) begin
            r_row_mem[i_wr.idx] <= i_wr.row;
        end
        if (i_rd_en) begin
            o_rd_tag <= r_tag_mem[i_rd_idx];
            o_rd_row <= r_row_mem[i_rd_idx];
        end
    end

endmodule

[design/dmcs_stats.sv]
// ----------------------------------------------------------------------------
// dmcs_stats
// Eight wrapping 32-bit traffic counters with a read select.
// ----------------------------------------------------------------------------
module dmcs_stats (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dmcs_pkg::t_stat_ctl        i_ctl,
    output logic [dmcs_pkg::CNT_W-1:0] o_value
);

    logic [dmcs_pkg::CNT_W-1:0] r_cnt [dmcs_pkg::NCNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dmcs_pkg::NCNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < dmcs_pkg::NCNT; k++) begin
                if (i_ctl.inc[k]) begin
                    r_cnt[k] <= r_cnt[k] + 1'b1;
                end
            end
        end
    end

    assign o_value = r_cnt[i_ctl.sel];

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the direct-mapped cache: directed and random requests in all
// write modes, checked beat by beat against a line/tag/counter predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] MODE_PLAIN = 2'd3;   // update on hit only
    localparam logic [2:0] REQ_UNUSED = 3'd7;   // no operation
    localparam int         DRAIN_CYC  = dmcs_pkg::LINE_COUNT + 8;
    localparam int         LINES      = dmcs_pkg::LINE_COUNT;
    localparam int         LBYTES     = dmcs_pkg::LINE_BYTES;
    localparam int         OFF_W      = dmcs_pkg::OFF_W;
    localparam int         IDX_W      = dmcs_pkg::IDX_W;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [1:0]                       cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [dmcs_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [2:0]                       s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [dmcs_pkg::OUT_TDATA_W-1:0] m_tdata;

    always #10 i_clk = ~i_clk;

    direct_mapped_cache_with_stats_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    // predicted cache contents
    logic [1:0]                 mode_q;
    logic [dmcs_pkg::TAG_W-1:0] tag_q   [LINES];
    bit                         valid_q [LINES];
    bit                         dirty_q [LINES];
    logic [7:0]                 byte_q  [LINES*LBYTES];
    logic [31:0]                stat_q  [dmcs_pkg::NCNT];

    dmcs_pkg::t_result resp_q[$];
    int      errors = 0;
    int      burst_left = 0;
    logic    rx_hold = 1'b0;

    function automatic void bump(logic [2:0] k);
        stat_q[k] = stat_q[k] + 32'd1;
    endfunction

    function automatic int evict_dirty(int idx);
        if (dirty_q[idx]) begin
            dirty_q[idx] = 0;
            bump(dmcs_pkg::CNT_WBACK);
            return 1;
        end
        return 0;
    endfunction

    function automatic dmcs_pkg::t_result cache_predict(logic [2:0] req, logic [15:0] addr,
                                                        logic [3:0] cnt_in, logic [63:0] wd);
        dmcs_pkg::t_result r;
        int off, idx, cnt, n;
        logic [dmcs_pkg::TAG_W-1:0] tg;
        bit hit;
        r   = '0;
        off = int'(addr[OFF_W-1:0]);
        idx = int'(addr[OFF_W+IDX_W-1:OFF_W]);
        tg  = addr[dmcs_pkg::ADDR_BITS-1:OFF_W+IDX_W];
        hit = valid_q[idx] && tag_q[idx] == tg;
        cnt = (cnt_in > 8) ? 8 : int'(cnt_in);
        n   = (cnt < LBYTES - off) ? cnt : LBYTES - off;
        case (req)
            dmcs_pkg::REQ_READ: if (cnt != 0) begin
                if (hit) begin
                    bump(dmcs_pkg::CNT_HIT); bump(dmcs_pkg::CNT_RD_HIT);
                    for (int i = 0; i < n; i++)
                        r.read_data[8*i +: 8] = byte_q[idx*LBYTES + off + i];
                    r.ok = 1; r.bytes_done = 4'(n);
                end else begin
                    bump(dmcs_pkg::CNT_MISS); bump(dmcs_pkg::CNT_RD_MISS);
                end
            end
            dmcs_pkg::REQ_WRITE: if (cnt != 0) begin
                if (hit) begin
                    bump(dmcs_pkg::CNT_HIT); bump(dmcs_pkg::CNT_WR_HIT);
                    for (int i = 0; i < n; i++)
                        byte_q[idx*LBYTES + off + i] = wd[8*i +: 8];
                    if (mode_q == dmcs_pkg::MODE_WBACK) begin
                        dirty_q[idx] = 1;
                    end else if (mode_q == dmcs_pkg::MODE_WTHRU) begin
                        r.memory_write = 1;
                        r.lines_written_back = 7'(evict_dirty(idx));
                    end
                    r.ok = 1; r.bytes_done = 4'(n);
                end else begin
                    bump(dmcs_pkg::CNT_MISS); bump(dmcs_pkg::CNT_WR_MISS);
                    if (mode_q == dmcs_pkg::MODE_WALLOC) begin
                        if (valid_q[idx]) begin
                            r.lines_written_back = 7'(evict_dirty(idx));
                            bump(dmcs_pkg::CNT_EVICT);
                        end
                        tag_q[idx] = tg; valid_q[idx] = 1; dirty_q[idx] = 0;
                        for (int i = 0; i < LBYTES; i++)
                            byte_q[idx*LBYTES + i] = '0;
                        for (int i = 0; i < n; i++)
                            byte_q[idx*LBYTES + off + i] = wd[8*i +: 8];
                        r.ok = 1; r.bytes_done = 4'(n);
                    end
                end
            end
            dmcs_pkg::REQ_INV_LINE: if (hit) begin
                r.lines_written_back = 7'(evict_dirty(idx));
                valid_q[idx] = 0; dirty_q[idx] = 0;
                r.ok = 1;
            end
            dmcs_pkg::REQ_FLS_LINE: if (hit) begin
                r.lines_written_back = 7'(evict_dirty(idx));
                r.ok = 1;
            end
            dmcs_pkg::REQ_INV_ALL: begin
                for (int i = 0; i < LINES; i++) begin
                    if (valid_q[i])
                        r.lines_written_back = r.lines_written_back + 7'(evict_dirty(i));
                    valid_q[i] = 0; dirty_q[i] = 0;
                end
                r.ok = 1;
            end
            dmcs_pkg::REQ_FLS_ALL: begin
                for (int i = 0; i < LINES; i++)
                    if (valid_q[i])
                        r.lines_written_back = r.lines_written_back + 7'(evict_dirty(i));
                r.ok = 1;
            end
            dmcs_pkg::REQ_COUNTER: begin
                r.counter_value = stat_q[addr[2:0]];
                r.ok = 1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_err(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // sender: bursts with random gaps, prediction on acceptance
    task automatic send_req(logic [2:0] req, logic [15:0] addr, logic [3:0] cnt,
                            logic [63:0] wd);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, wd, cnt, addr};
        do @(posedge i_clk); while (!s_tready);
        resp_q.push_back(cache_predict(req, addr, cnt, wd));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        mode_q = m;
        @(posedge i_clk);
    endtask

    // receiver: stall density changes every so often, plus a long hold-off
    int rx_pct = 100;
    int rx_cyc = 0;
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc % 64 == 0) begin
            case ($urandom_range(0, 2))
                0: rx_pct <= 100;
                1: rx_pct <= 60;
                default: rx_pct <= 25;
            endcase
        end
        m_tready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) < rx_pct);
    end

    always @(posedge i_clk) begin
        dmcs_pkg::t_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = dmcs_pkg::t_result'(m_tdata[$bits(dmcs_pkg::t_result)-1:0]);
            if (resp_q.size() == 0) begin
                report_err("unexpected beat", m_tdata[63:0], '0);
            end else begin
                want = resp_q.pop_front();
                if (got.ok != want.ok)
                    report_err("ok", 64'(got.ok), 64'(want.ok));
                if (got.read_data != want.read_data)
                    report_err("read_data", got.read_data, want.read_data);
                if (got.bytes_done != want.bytes_done)
                    report_err("bytes_done", 64'(got.bytes_done), 64'(want.bytes_done));
                if (got.memory_write != want.memory_write)
                    report_err("memory_write", 64'(got.memory_write),
                               64'(want.memory_write));
                if (got.lines_written_back != want.lines_written_back)
                    report_err("lines_written_back", 64'(got.lines_written_back),
                               64'(want.lines_written_back));
                if (got.counter_value != want.counter_value)
                    report_err("counter_value", 64'(got.counter_value),
                               64'(want.counter_value));
            end
        end
    end

    task automatic test_directed();
        logic [63:0] ones = '1;
        set_mode(dmcs_pkg::MODE_WALLOC);
        send_req(dmcs_pkg::REQ_READ, 16'h0000, 4'd8, '0);          // cold miss
        send_req(dmcs_pkg::REQ_WRITE, 16'h0000, 4'd8, ones);       // allocate
        send_req(dmcs_pkg::REQ_READ, 16'h0000, 4'd8, '0);
        send_req(dmcs_pkg::REQ_READ, 16'h000C, 4'd8, '0);          // clipped at line end
        send_req(dmcs_pkg::REQ_READ, 16'h0003, 4'd0, '0);          // zero count
        send_req(dmcs_pkg::REQ_WRITE, 16'h0003, 4'd0, ones);
        send_req(dmcs_pkg::REQ_WRITE, 16'hFFFF, 4'd15, 64'h0123_4567_89AB_CDEF);
        send_req(dmcs_pkg::REQ_READ, 16'hFFF8, 4'd15, '0);
        send_req(REQ_UNUSED, 16'hFFFF, 4'd15, ones);
        set_mode(dmcs_pkg::MODE_WBACK);
        send_req(dmcs_pkg::REQ_WRITE, 16'h0004, 4'd2, 64'hA5A5);   // dirty line
        send_req(dmcs_pkg::REQ_FLS_LINE, 16'h0000, 4'd1, '0);
        send_req(dmcs_pkg::REQ_FLS_LINE, 16'h0000, 4'd1, '0);      // now clean
        send_req(dmcs_pkg::REQ_WRITE, 16'h0004, 4'd1, 64'h5A);
        set_mode(dmcs_pkg::MODE_WTHRU);
        send_req(dmcs_pkg::REQ_WRITE, 16'h0005, 4'd1, 64'h77);     // through on dirty line
        send_req(dmcs_pkg::REQ_WRITE, 16'h4000, 4'd4, ones);       // miss, no allocate
        set_mode(MODE_PLAIN);
        send_req(dmcs_pkg::REQ_WRITE, 16'h0006, 4'd3, ones);
        send_req(dmcs_pkg::REQ_WRITE, 16'h8000, 4'd3, ones);
        send_req(dmcs_pkg::REQ_INV_LINE, 16'h0000, 4'd0, '0);
        send_req(dmcs_pkg::REQ_INV_LINE, 16'h0000, 4'd0, '0);      // miss
        send_req(dmcs_pkg::REQ_FLS_ALL, 16'h0000, 4'd0, '0);
        send_req(dmcs_pkg::REQ_INV_ALL, 16'h0000, 4'd0, '0);
        for (int k = 0; k < dmcs_pkg::NCNT; k++)
            send_req(dmcs_pkg::REQ_COUNTER, 16'(k), 4'd0, '0);
    endtask

    task automatic test_random(logic [1:0] m, int count);
        logic [2:0]  req;
        logic [15:0] addr;
        logic [3:0]  cnt;
        int          pick;
        set_mode(m);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 36)      req = dmcs_pkg::REQ_READ;
            else if (pick < 72) req = dmcs_pkg::REQ_WRITE;
            else if (pick < 79) req = dmcs_pkg::REQ_INV_LINE;
            else if (pick < 86) req = dmcs_pkg::REQ_FLS_LINE;
            else if (pick < 88) req = dmcs_pkg::REQ_INV_ALL;
            else if (pick < 90) req = dmcs_pkg::REQ_FLS_ALL;
            else if (pick < 98) req = dmcs_pkg::REQ_COUNTER;
            else                req = REQ_UNUSED;
            // few tags and lines most of the time so hits and evictions happen
            if ($urandom_range(0, 9) == 0)
                addr = 16'($urandom);
            else
                addr = {6'($urandom_range(0, 2)), 6'($urandom_range(0, 7)),
                        4'($urandom)};
            cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
            send_req(req, addr, cnt, {$urandom, $urandom});
        end
    endtask

    task automatic test_backpressure();
        set_mode(dmcs_pkg::MODE_WALLOC);
        rx_hold <= 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            for (int k = 0; k < 20; k++)
                send_req(k % 2 ? dmcs_pkg::REQ_READ : dmcs_pkg::REQ_WRITE,
                         {6'd1, 6'(k % 4), 4'd0}, 4'd8, {$urandom, $urandom});
        join
    endtask

    initial begin
        mode_q = dmcs_pkg::MODE_WBACK;
        for (int i = 0; i < LINES; i++) begin
            valid_q[i] = 0; dirty_q[i] = 0; tag_q[i] = '0;
        end
        for (int i = 0; i < dmcs_pkg::NCNT; i++) stat_q[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(dmcs_pkg::MODE_WALLOC, 130);
        test_random(dmcs_pkg::MODE_WBACK, 100);
        test_backpressure();
        test_random(dmcs_pkg::MODE_WALLOC, 100);
        test_random(dmcs_pkg::MODE_WTHRU, 100);
        test_random(MODE_PLAIN, 60);
        test_random(dmcs_pkg::MODE_WALLOC, 40);
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
